// ----- design/gcol_pkg.sv -----
// Shared types and constants for the greedy graph coloring block.
// Used by gcol_ctrl, gcol_dp and greedy_graph_coloring; depends on nothing.
package gcol_pkg;

  localparam int NODE_W        = 10;
  localparam int COLOR_W       = 6;
  localparam int MASK_W        = 64;
  localparam int GROUP_W       = 8;
  localparam int NGROUPS       = MASK_W / GROUP_W;
  localparam int GIDX_W        = 3;
  localparam int MAX_COLORS    = 64;
  localparam int DEF_MAX_NODES = 1024;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [NODE_W-1:0] neighbor_index;
    logic              has_neighbor;
    logic              last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0]  colored_node;
    logic [COLOR_W-1:0] assigned_color;
    logic               color_overflow;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // latch the accepted item and start the color-store read
    logic mark;   // fold the read color into the used mask
    logic scan;   // first search stage over the used mask
    logic emit;   // write the color store, load the result, clear the mask
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_last;  // the held item ends its node
    logic out_busy;   // the result register is full and not taken this cycle
  } ctrl_sts_t;

endpackage

// ----- design/gcol_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module gcol_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/gcol_ctrl.sv -----
// Controller state machine for the greedy graph coloring block.
// Depends on gcol_pkg; drives the datapath gcol_dp through ctrl_cmd_t.
module gcol_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcol_pkg::ctrl_sts_t sts,
  output gcol_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.mark  = 1'b1;
        state_nxt = sts.item_last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold the finished color until the result register can take it.
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ----- design/gcol_dp.sv -----
// Datapath: held item, used-color mask, two-stage first-free search, color store
// and result register. Depends on gcol_pkg and gcol_ram.
module gcol_dp #(
  parameter int MaxNodes = gcol_pkg::DEF_MAX_NODES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gcol_pkg::in_item_t  in_data,
  input  gcol_pkg::ctrl_cmd_t cmd,
  output gcol_pkg::ctrl_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output gcol_pkg::out_item_t out_data
);

  localparam int AddrW = $clog2(MaxNodes);

  logic [gcol_pkg::NODE_W-1:0]   node_r;
  logic                          mark_en_r;
  logic                          last_r;
  logic [gcol_pkg::MASK_W-1:0]   mask_r, mask_nxt;
  logic [gcol_pkg::NGROUPS-1:0]  grp_zero_r, grp_zero_nxt;
  logic [gcol_pkg::GIDX_W-1:0]   grp_idx_r [gcol_pkg::NGROUPS];
  logic [gcol_pkg::GIDX_W-1:0]   grp_idx_nxt [gcol_pkg::NGROUPS];
  logic [gcol_pkg::COLOR_W-1:0]  pick;
  logic                          found;
  logic                          out_valid_r;
  gcol_pkg::out_item_t           out_data_r;
  logic [gcol_pkg::COLOR_W-1:0]  rd_color;
  logic                          mark_en;
  logic                          wr_en;

  // A neighbor counts only if it is present, below the node and inside the store.
  assign mark_en = in_data.has_neighbor &&
                   (in_data.neighbor_index < in_data.node_index) &&
                   (32'(in_data.neighbor_index) < MaxNodes);
  assign wr_en   = cmd.emit && (32'(node_r) < MaxNodes);

  gcol_ram #(
    .Width (gcol_pkg::COLOR_W),
    .Depth (MaxNodes)
  ) u_color_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AddrW'(node_r)),
    .wdata (pick),
    .re    (cmd.load),
    .raddr (AddrW'(in_data.neighbor_index)),
    .rdata (rd_color)
  );

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.emit) begin
      mask_nxt = '0;
    end else if (cmd.mark && mark_en_r) begin
      mask_nxt = mask_r | (gcol_pkg::MASK_W'(1) << rd_color);
    end
  end

  // Search stage one: per group of eight colors, is one free and which is first.
  // Colors at or above the color limit count as used.
  always_comb begin
    logic [gcol_pkg::MASK_W-1:0] eff;
    for (int c = 0; c < gcol_pkg::MASK_W; c++) begin
      eff[c] = mask_r[c] || (c >= gcol_pkg::MAX_COLORS);
    end
    for (int g = 0; g < gcol_pkg::NGROUPS; g++) begin
      grp_zero_nxt[g] = 1'b0;
      grp_idx_nxt[g]  = '0;
      for (int b = gcol_pkg::GROUP_W - 1; b >= 0; b--) begin
        if (!eff[g * gcol_pkg::GROUP_W + b]) begin
          grp_zero_nxt[g] = 1'b1;
          grp_idx_nxt[g]  = gcol_pkg::GIDX_W'(b);
        end
      end
    end
  end

  // Search stage two: the first group with a free color gives the pick.
  always_comb begin
    pick  = gcol_pkg::COLOR_W'(gcol_pkg::MAX_COLORS - 1);
    found = 1'b0;
    for (int g = gcol_pkg::NGROUPS - 1; g >= 0; g--) begin
      if (grp_zero_r[g]) begin
        pick  = {gcol_pkg::GIDX_W'(g), grp_idx_r[g]};
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r    <= in_data.node_index;
      mark_en_r <= mark_en;
      last_r    <= in_data.last_neighbor;
    end
    if (cmd.scan) begin
      grp_zero_r <= grp_zero_nxt;
      for (int g = 0; g < gcol_pkg::NGROUPS; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
    if (cmd.emit) begin
      out_data_r.colored_node   <= node_r;
      out_data_r.assigned_color <= pick;
      out_data_r.color_overflow <= !found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.item_last = last_r;
  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ----- design/greedy_graph_coloring.sv -----
// Top level of the first-fit greedy graph coloring block.
// Depends on gcol_pkg, gcol_ctrl, gcol_dp (which holds gcol_ram).
//
//   channel | ports                         | moves
//   --------+-------------------------------+--------------------------------------
//   input   | in_valid, in_ready, in_data   | one adjacency item per transaction
//   result  | out_valid, out_ready, out_data| one colored node per last item
//
// An item without last_neighbor is accepted, then the color-store read lands and is
// folded into the used mask. An item with last_neighbor goes on through the read, the
// two search stages over the 64-bit mask, and the store write and result load.
// Reset is synchronous and needs no clearing pass; the color store is not cleared.
// A held result stalls only the emit step of the next node's last item.
module greedy_graph_coloring #(
  parameter int MaxNodes = gcol_pkg::DEF_MAX_NODES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gcol_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gcol_pkg::out_item_t out_data
);

  gcol_pkg::ctrl_cmd_t cmd;
  gcol_pkg::ctrl_sts_t sts;

  gcol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcol_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // One item at a time: in the cycle after an accepted transaction the input is closed.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  // Results appear only from an emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result valid without emit");
`endif

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for greedy_graph_coloring: predicts each colored node and
// compares it with the result channel. Depends on gcol_pkg and the RTL in design/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NODE_COUNT   = 1 << gcol_pkg::NODE_W;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  gcol_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  gcol_pkg::out_item_t out_data;

  greedy_graph_coloring dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6ns clk = ~clk;

  // Predictor state: stored colors, the mask of the node in progress, and which
  // nodes have been colored so that no uncolored lower neighbor is ever sent.
  logic [gcol_pkg::COLOR_W-1:0] node_color [NODE_COUNT];
  logic [gcol_pkg::MASK_W-1:0]  used_colors = '0;
  bit                           node_colored [NODE_COUNT];
  int                           colored_nodes[$];
  gcol_pkg::out_item_t          expected_colors[$];
  gcol_pkg::out_item_t          want_res;

  int fail_count  = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int rand_node   = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void predict_coloring(input gcol_pkg::in_item_t item);
    gcol_pkg::out_item_t res;
    int c;
    if (item.has_neighbor && item.neighbor_index < item.node_index)
      used_colors[node_color[item.neighbor_index]] = 1'b1;
    if (item.last_neighbor) begin
      res.colored_node   = item.node_index;
      res.assigned_color = gcol_pkg::COLOR_W'(gcol_pkg::MAX_COLORS - 1);
      res.color_overflow = 1'b1;
      for (c = 0; c < gcol_pkg::MAX_COLORS; c++) begin
        if (!used_colors[c]) begin
          res.assigned_color = gcol_pkg::COLOR_W'(c);
          res.color_overflow = 1'b0;
          break;
        end
      end
      node_color[item.node_index] = res.assigned_color;
      used_colors = '0;
      if (!node_colored[item.node_index]) begin
        node_colored[item.node_index] = 1'b1;
        colored_nodes.push_back(int'(item.node_index));
      end
      expected_colors.push_back(res);
    end
  endfunction

  // Valid is only lowered when the sender goes idle, so back-to-back transactions
  // never see a low and a high assignment in the same step.
  task automatic send_adjacency(input int node, input int nb, input bit has, input bit last);
    gcol_pkg::in_item_t item;
    item.node_index     = gcol_pkg::NODE_W'(node);
    item.neighbor_index = gcol_pkg::NODE_W'(nb);
    item.has_neighbor   = has;
    item.last_neighbor  = last;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    predict_coloring(item);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $error("unexpected result for node %0d", out_data.colored_node);
        fail_count++;
      end else begin
        want_res = expected_colors.pop_front();
        if (out_data.colored_node !== want_res.colored_node) begin
          $error("colored_node: expected %0d, actual %0d",
                 want_res.colored_node, out_data.colored_node);
          fail_count++;
        end
        if (out_data.assigned_color !== want_res.assigned_color) begin
          $error("assigned_color: expected %0d, actual %0d",
                 want_res.assigned_color, out_data.assigned_color);
          fail_count++;
        end
        if (out_data.color_overflow !== want_res.color_overflow) begin
          $error("color_overflow: expected %0d, actual %0d",
                 want_res.color_overflow, out_data.color_overflow);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_adjacency(0, 0, 1'b0, 1'b1);       // node with no neighbors
    send_adjacency(1, 0, 1'b1, 1'b1);
    send_adjacency(2, 2, 1'b1, 1'b0);       // self loop
    send_adjacency(2, 1023, 1'b1, 1'b0);    // neighbor not yet colored
    send_adjacency(2, 0, 1'b0, 1'b0);       // item without neighbor
    send_adjacency(2, 1, 1'b1, 1'b1);
    send_adjacency(3, 0, 1'b1, 1'b0);
    send_adjacency(3, 1, 1'b1, 1'b0);
    send_adjacency(3, 2, 1'b1, 1'b0);
    send_adjacency(3, 1023, 1'b0, 1'b1);
    // The node index changes in the middle of a run; the mask keeps accumulating.
    send_adjacency(1023, 3, 1'b1, 1'b0);
    send_adjacency(4, 3, 1'b1, 1'b0);
    send_adjacency(5, 0, 1'b1, 1'b1);
    send_adjacency(1023, 0, 1'b1, 1'b0);
    send_adjacency(1023, 1, 1'b1, 1'b0);
    send_adjacency(1023, 1022, 1'b0, 1'b0);
    send_adjacency(1023, 3, 1'b1, 1'b0);
    send_adjacency(1023, 1023, 1'b1, 1'b1);
    send_adjacency(1000, 1023, 1'b1, 1'b1);
    drain_results();
  endtask

  // Builds a clique on nodes 100 to 163 so that node 100+k gets color k; node 164 is
  // adjacent to all of them and runs out of colors.
  task automatic test_color_overflow();
    int k;
    int j;
    idle_pct  = 10;
    stall_pct = 10;
    send_adjacency(100, 0, 1'b0, 1'b1);
    for (k = 1; k <= gcol_pkg::MAX_COLORS; k++)
      for (j = 0; j < k; j++)
        send_adjacency(100 + k, 100 + j, 1'b1, j == k - 1);
    for (j = 0; j < gcol_pkg::MAX_COLORS - 1; j++)
      send_adjacency(165, 100 + j, 1'b1, j == gcol_pkg::MAX_COLORS - 2);
    send_adjacency(166, 164, 1'b1, 1'b0);
    send_adjacency(166, 100, 1'b1, 1'b1);
    drain_results();
  endtask

  // Returns a colored node below the given one, favoring recently colored nodes so
  // that neighborhoods overlap and colors climb; -1 if none was found.
  function automatic int pick_colored_below(input int node);
    int n;
    int idx;
    int k;
    n = colored_nodes.size();
    for (k = 0; k < 8 && n > 0; k++) begin
      if (k % 2 == 0 && n > 16) idx = $urandom_range(n - 1, n - 16);
      else idx = $urandom_range(n - 1, 0);
      if (colored_nodes[idx] < node) return colored_nodes[idx];
    end
    return -1;
  endfunction

  task automatic test_random_graph(input int n_items, input int idle, input int stall);
    int sent;
    int deg;
    int i;
    int item_node;
    int nb;
    int pick;
    bit has;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) rand_node = (rand_node + 1) % NODE_COUNT;
      else rand_node = $urandom_range(NODE_COUNT - 1, 0);
      deg = ($urandom_range(99) < 80) ? $urandom_range(4, 1) : $urandom_range(12, 5);
      for (i = 0; i < deg; i++) begin
        item_node = ($urandom_range(99) < 3) ? $urandom_range(NODE_COUNT - 1, 0) : rand_node;
        pick = $urandom_range(99);
        has  = 1'b1;
        if (pick < 65) begin
          nb = pick_colored_below(item_node);
          if (nb < 0) nb = item_node;
        end else if (pick < 80) begin
          nb = $urandom_range(NODE_COUNT - 1, item_node);
        end else begin
          has = 1'b0;
          nb  = $urandom_range(NODE_COUNT - 1, 0);
        end
        send_adjacency(item_node, nb, has, i == deg - 1);
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_color_overflow();
    rand_node = $urandom_range(NODE_COUNT - 1, 0);
    test_random_graph(200, 0, 0);
    test_random_graph(200, 62, 0);
    test_random_graph(200, 0, 62);
    test_random_graph(200, 10, 10);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
